// ----- src/llgheun_pkg.sv -----
`default_nettype none

package llgheun_pkg;

  localparam int ATOM_COUNT_DEF = 4096;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS = 31;
  localparam int MAG_W = 52;
  // 16 front stages, sqrt, divider setup, divider, output formatting
  localparam int DEPTH = 16 + SQRT_STEPS + 1 + DIV_STEPS + 1;

  typedef struct packed {
    logic act;
    logic rng;
    logic [11:0] atom;
  } tag_t;

  typedef struct packed {
    logic [2:0][31:0] s;
    logic [2:0][47:0] t;
  } mem_t;

  typedef struct packed {
    logic [11:0] atom;
    logic zero;
    logic [2:0] neg;
    logic [2:0][30:0] nm;
  } nrm_t;

  typedef struct packed {
    logic [11:0] atom;
    logic zero;
    logic [2:0] neg;
    logic [31:0] m;
    logic [2:0][31:0] rem;
    logic [2:0][30:0] low;
    logic [2:0][30:0] q;
  } div_t;

  // floor((p - q) / 2^30), saturated to 32 bits
  function automatic logic signed [31:0] cross_term(input logic signed [63:0] p,
                                                    input logic signed [63:0] q);
    logic signed [64:0] d;
    logic signed [34:0] f;
    d = $signed({p[63], p}) - $signed({q[63], q});
    f = $signed(d[64:30]);
    if (f > 35'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (f < -35'sd2147483648) begin
      return 32'sh8000_0000;
    end else begin
      return $signed(f[31:0]);
    end
  endfunction

endpackage

`default_nettype wire

// ----- src/llg_heun_spin_step_unit.sv -----
`default_nettype none

// Channel   | Handshake              | Payload
// config    | cfg_write              | cfg_data (time step, Q0.32)
// request   | in_valid / in_stall    | action, atom_index, spin_*, field_*, coeffs
// result    | out_valid / out_stall  | out_atom, new_spin_*
//
// One request per cycle while in_stall is low; 81 pipeline stages plus the
// output register. The depth is set by the 32-step square root and
// 31-step divider.
// Synchronous reset clears valid bits and the time step; the per-atom
// store is not cleared. Output stall freezes the pipeline only when its
// last stage holds a result; while that stage is empty, the pipeline advances.

module llg_heun_spin_step_unit #(
  parameter int ATOM_COUNT = llgheun_pkg::ATOM_COUNT_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic        [31:0] cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               action,
  input  wire logic        [11:0] atom_index,
  input  wire logic signed [31:0] spin_x,
  input  wire logic signed [31:0] spin_y,
  input  wire logic signed [31:0] spin_z,
  input  wire logic signed [31:0] field_x,
  input  wire logic signed [31:0] field_y,
  input  wire logic signed [31:0] field_z,
  input  wire logic        [31:0] prec_coeff,
  input  wire logic        [31:0] damp_coeff,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic             [11:0] out_atom,
  output logic signed      [31:0] new_spin_x,
  output logic signed      [31:0] new_spin_y,
  output logic signed      [31:0] new_spin_z
);

  localparam int AW = (ATOM_COUNT > 1) ? $clog2(ATOM_COUNT) : 1;
  localparam int DEPTH = llgheun_pkg::DEPTH;
  localparam int SQ = llgheun_pkg::SQRT_STEPS;
  localparam int DV = llgheun_pkg::DIV_STEPS;
  localparam int MW = llgheun_pkg::MAG_W;

  logic [31:0] ts;
  logic [DEPTH:1] vp;
  logic en, out_free;

  assign out_free = !out_valid || !out_stall;
  assign en = out_free || !vp[DEPTH];
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      ts <= '0;
      vp <= '0;
    end else begin
      if (cfg_write) begin
        ts <= cfg_data;
      end
      if (en) begin
        vp <= {vp[DEPTH-1:1], in_valid};
      end
    end
  end

  // stage 1: capture
  llgheun_pkg::tag_t tag1, tag2, tag3, tag4, tag5, tag6, tag7, tag8, tag9, tag10;
  logic signed [31:0] s1 [3], s2 [3], s3 [3], s4 [3], s5 [3], s6 [3], s7 [3], s8 [3];
  logic signed [31:0] h1 [3];
  logic [31:0] pc1, dc1, pc2, dc2, pc3, dc3, pc4, dc4, pc5, dc5;

  always_ff @(posedge clk) begin
    if (en) begin
      tag1.act <= action;
      tag1.rng <= 32'(atom_index) < 32'(ATOM_COUNT);
      tag1.atom <= atom_index;
      s1[0] <= spin_x;
      s1[1] <= spin_y;
      s1[2] <= spin_z;
      h1[0] <= field_x;
      h1[1] <= field_y;
      h1[2] <= field_z;
      pc1 <= (prec_coeff > 32'h8000_0000) ? 32'h8000_0000 : prec_coeff;
      dc1 <= (damp_coeff > 32'h8000_0000) ? 32'h8000_0000 : damp_coeff;
    end
  end

  // stages 2-3: c = S x H
  logic signed [63:0] pa2 [3], pb2 [3];
  logic signed [31:0] c3 [3], c4 [3], c5 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      pa2[0] <= s1[1] * h1[2];
      pb2[0] <= s1[2] * h1[1];
      pa2[1] <= s1[2] * h1[0];
      pb2[1] <= s1[0] * h1[2];
      pa2[2] <= s1[0] * h1[1];
      pb2[2] <= s1[1] * h1[0];
      tag2 <= tag1;
      s2 <= s1;
      pc2 <= pc1;
      dc2 <= dc1;
      for (int i = 0; i < 3; i++) begin
        c3[i] <= llgheun_pkg::cross_term(pa2[i], pb2[i]);
      end
      tag3 <= tag2;
      s3 <= s2;
      pc3 <= pc2;
      dc3 <= dc2;
    end
  end

  // stages 4-5: d = S x c
  logic signed [63:0] pa4 [3], pb4 [3];
  logic signed [31:0] d5 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      pa4[0] <= s3[1] * c3[2];
      pb4[0] <= s3[2] * c3[1];
      pa4[1] <= s3[2] * c3[0];
      pb4[1] <= s3[0] * c3[2];
      pa4[2] <= s3[0] * c3[1];
      pb4[2] <= s3[1] * c3[0];
      tag4 <= tag3;
      s4 <= s3;
      c4 <= c3;
      pc4 <= pc3;
      dc4 <= dc3;
      for (int i = 0; i < 3; i++) begin
        d5[i] <= llgheun_pkg::cross_term(pa4[i], pb4[i]);
      end
      tag5 <= tag4;
      s5 <= s4;
      c5 <= c4;
      pc5 <= pc4;
      dc5 <= dc4;
    end
  end

  // stages 6-7: torque
  logic signed [63:0] pp6 [3], dp6 [3];
  logic signed [47:0] t7 [3], t8 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pp6[i] <= $signed({1'b0, pc5}) * c5[i];
        dp6[i] <= $signed({1'b0, dc5}) * d5[i];
        t7[i] <= $signed(pp6[i][63:23]) + $signed(dp6[i][63:23]);
      end
      tag6 <= tag5;
      s6 <= s5;
      tag7 <= tag6;
      s7 <= s6;
    end
  end

  // stage 8: per-atom store
  llgheun_pkg::mem_t mem [ATOM_COUNT];
  llgheun_pkg::mem_t rd8, wd7;
  logic [AW-1:0] adr7;

  assign adr7 = AW'(tag7.atom);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wd7.s[i] = s7[i];
      wd7.t[i] = t7[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en && vp[7] && !tag7.act && tag7.rng) begin
      mem[adr7] <= wd7;
    end
    if (en) begin
      rd8 <= mem[adr7];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag8 <= tag7;
      s8 <= s7;
      t8 <= t7;
    end
  end

  // stage 9: pick predictor or corrector operands
  logic signed [47:0] tt9 [3];
  logic signed [31:0] b9 [3], b10 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (tag8.act) begin
          tt9[i] <= (tag8.rng ? $signed(rd8.t[i]) : 48'sd0) + t8[i];
          b9[i] <= tag8.rng ? $signed(rd8.s[i]) : 32'sd0;
        end else begin
          tt9[i] <= t8[i];
          b9[i] <= s8[i];
        end
      end
      tag9 <= tag8;
    end
  end

  // stages 10-11: step = floor(tt * dt / 2^k), v = base + step
  logic signed [56:0] ph10 [3];
  logic [55:0] pl10 [3];
  logic signed [51:0] v11 [3];
  logic signed [81:0] full11 [3], step11 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      full11[i] = $signed({ph10[i][56], ph10[i], 24'b0}) + $signed({26'b0, pl10[i]});
      step11[i] = tag10.act ? (full11[i] >>> 27) : (full11[i] >>> 26);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ph10[i] <= $signed(tt9[i][47:24]) * $signed({1'b0, ts});
        pl10[i] <= tt9[i][23:0] * ts;
        v11[i] <= $signed({{20{b10[i][31]}}, b10[i]}) + $signed(step11[i][51:0]);
      end
      b10 <= b9;
      tag10 <= tag9;
    end
  end

  logic [11:0] atom11, atom12, atom13, atom14;
  always_ff @(posedge clk) begin
    if (en) begin
      atom11 <= tag10.atom;
      atom12 <= atom11;
      atom13 <= atom12;
      atom14 <= atom13;
    end
  end

  // stages 12-14: magnitudes, leading one, common shift
  logic [MW-1:0] mag12 [3], mag13 [3], orv12;
  logic [2:0] neg12, neg13, neg14;
  logic [5:0] pos12, amt13;
  logic rsh13, zero13, zero14;
  logic [30:0] nm14 [3];
  logic [61:0] sq15 [3];

  assign orv12 = mag12[0] | mag12[1] | mag12[2];

  always_comb begin
    pos12 = '0;
    for (int b = 0; b < MW; b++) begin
      if (orv12[b]) begin
        pos12 = 6'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg12[i] <= v11[i][51];
        mag12[i] <= v11[i][51] ? MW'(-v11[i]) : MW'(v11[i]);
      end
      mag13 <= mag12;
      neg13 <= neg12;
      zero13 <= (orv12 == '0);
      rsh13 <= pos12 > 6'd30;
      amt13 <= (pos12 > 6'd30) ? (pos12 - 6'd30) : (6'd30 - pos12);
      for (int i = 0; i < 3; i++) begin
        nm14[i] <= rsh13 ? 31'(mag13[i] >> amt13) : 31'(mag13[i] << amt13);
        sq15[i] <= nm14[i] * nm14[i];
      end
      neg14 <= neg13;
      zero14 <= zero13;
    end
  end

  // stage 16 and square root stages
  logic [63:0] sqn [SQ+1];
  logic [63:0] sqr [SQ+1];
  llgheun_pkg::nrm_t sqp [SQ+1];
  llgheun_pkg::nrm_t nrm14, nrm15;

  always_comb begin
    nrm14.atom = atom14;
    nrm14.zero = zero14;
    nrm14.neg = neg14;
    for (int i = 0; i < 3; i++) begin
      nrm14.nm[i] = nm14[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nrm15 <= nrm14;
      sqn[0] <= 64'(sq15[0]) + 64'(sq15[1]) + 64'(sq15[2]);
      sqr[0] <= '0;
      sqp[0] <= nrm15;
    end
  end

  for (genvar g = 0; g < SQ; g++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * g);
    logic [63:0] trial;
    assign trial = sqr[g] + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (sqn[g] >= trial) begin
          sqn[g+1] <= sqn[g] - trial;
          sqr[g+1] <= (sqr[g] >> 1) + BIT;
        end else begin
          sqn[g+1] <= sqn[g];
          sqr[g+1] <= sqr[g] >> 1;
        end
        sqp[g+1] <= sqp[g];
      end
    end
  end

  // divider setup: N = mag * 2^30 + m/2
  llgheun_pkg::div_t dv [DV+1];
  llgheun_pkg::div_t dv0;
  logic [31:0] m_sq;
  logic [61:0] num [3];

  assign m_sq = sqr[SQ][31:0];

  always_comb begin
    dv0.atom = sqp[SQ].atom;
    dv0.zero = sqp[SQ].zero;
    dv0.neg = sqp[SQ].neg;
    dv0.m = m_sq;
    for (int i = 0; i < 3; i++) begin
      num[i] = {1'b0, sqp[SQ].nm[i], 30'b0} + 62'(m_sq >> 1);
      dv0.rem[i] = {1'b0, num[i][61:31]};
      dv0.low[i] = num[i][30:0];
      dv0.q[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0] <= dv0;
    end
  end

  for (genvar g = 0; g < DV; g++) begin : g_div
    llgheun_pkg::div_t nx;
    logic [32:0] r33 [3];
    always_comb begin
      nx = dv[g];
      for (int i = 0; i < 3; i++) begin
        r33[i] = {dv[g].rem[i], dv[g].low[i][DV-1-g]};
        if (r33[i] >= {1'b0, dv[g].m}) begin
          nx.rem[i] = 32'(r33[i] - {1'b0, dv[g].m});
          nx.q[i][DV-1-g] = 1'b1;
        end else begin
          nx.rem[i] = r33[i][31:0];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv[g+1] <= nx;
      end
    end
  end

  // final stage and output register
  logic [11:0] atom_f;
  logic signed [31:0] res_f [3];

  always_ff @(posedge clk) begin
    if (en) begin
      atom_f <= dv[DV].atom;
      for (int i = 0; i < 3; i++) begin
        if (dv[DV].zero) begin
          res_f[i] <= '0;
        end else if (dv[DV].neg[i]) begin
          res_f[i] <= -$signed({1'b0, dv[DV].q[i]});
        end else begin
          res_f[i] <= $signed({1'b0, dv[DV].q[i]});
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= vp[DEPTH];
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_atom <= atom_f;
      new_spin_x <= res_f[0];
      new_spin_y <= res_f[1];
      new_spin_z <= res_f[2];
    end
  end

endmodule

`default_nettype wire
